@@ rtl/core/sacii_pkg.sv @@
// shared types and constants of the stuck adc code interpolator
package sacii_pkg;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 12;
   localparam int SAMPLE_BITS = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEDESTAL  = 1'b1;

   localparam logic [4:0]  RUN_LIMIT_RESET = 5'd16;
   localparam logic [11:0] PEDESTAL_RESET  = 12'd2048;
   localparam logic [5:0]  STUCK_MASK      = 6'h3F;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] adc_sample;
      logic                   last_of_waveform;
   } req_word_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] corrected_sample;
      logic                   was_replaced;
      logic                   end_of_waveform;
   } rsp_word_type;

   function automatic logic is_stuck(input logic [5:0] low);
      return (low == 6'h00) || (low == STUCK_MASK);
   endfunction

endpackage

@@ rtl/core/sacii_front.sv @@
// input queue that takes sample words and classifies them as stuck
module sacii_front #(
   parameter int SW = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sacii_pkg::req_word_type in_word,
   output logic                   full,
   output logic                   out_valid,
   input  logic                   out_pop,
   output logic [SW-1:0]          out_sample,
   output logic                   out_last,
   output logic                   out_stuck
);
   import sacii_pkg::*;

   localparam int EW = SW + 2;

   logic [EW-1:0] q_ff [2];
   logic          wp_ff, wp_in;
   logic          rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [SW-1:0] sample_in;
   logic          do_push, do_pop;

   assign sample_in = SW'(in_word.adc_sample);
   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = out_pop && out_valid;
   assign {out_sample, out_last, out_stuck} = q_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= {sample_in, in_word.last_of_waveform, is_stuck(sample_in[5:0])};
      end
   end

endmodule

@@ rtl/core/sacii_div.sv @@
// restoring divider, one quotient bit per cycle
module sacii_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             qbit;

   assign done = done_ff;
   assign quot = quo_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], qbit};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

@@ rtl/core/sacii_back.sv @@
// look-ahead window, stuck run search, interpolation and result queue
module sacii_back #(
   parameter int MAX_RUN = 16,
   parameter int SW      = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [4:0]             limit,
   input  logic [11:0]            pedestal,
   input  logic                   in_valid,
   output logic                   in_pop,
   input  logic [SW-1:0]          in_sample,
   input  logic                   in_last,
   input  logic                   in_stuck,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output sacii_pkg::rsp_word_type rsp_word
);
   import sacii_pkg::*;

   localparam int DEPTH = MAX_RUN + 1;
   localparam int PW    = $clog2(DEPTH);
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int DEN_W = FW;
   localparam int NUM_W = SW + PW + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_HEAD, S_SRCH, S_SCHK, S_MUL, S_DSTART, S_DIV
   } state_type;

   state_type        state_ff, state_in;
   logic [PW-1:0]    head_ff, head_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             last_ff, last_in;
   logic             start_ff, start_in;
   logic [SW-1:0]    prev_ff, prev_in;
   logic [PW-1:0]    off_ff, off_in;
   logic [SW-1:0]    endp_ff, endp_in;
   logic [SW-1:0]    val_ff, val_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic             emit_ff, emit_in;

   logic [SW-1:0]    win_mem_ff [DEPTH];
   logic [SW-1:0]    rd_ff;
   logic             arr_ff [DEPTH];
   logic             mem_we;
   logic [PW-1:0]    mem_wa, mem_ra, tail;
   logic [SW-1:0]    mem_wd;

   logic [PW-1:0]    lim;
   logic [SW-1:0]    ped;
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_quot;
   logic [FW-1:0]    off_next;

   rsp_word_type     oq_ff [2];
   logic             oq_wp_ff, oq_rp_ff;
   logic [1:0]       oq_cnt_ff;
   logic             oq_full, oq_push, oq_pop;
   rsp_word_type     oq_word;

   function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
      return s[PW-1:0];
   endfunction

   assign lim      = (32'(limit) > MAX_RUN) ? PW'(MAX_RUN) : PW'(limit);
   assign ped      = SW'(pedestal);
   assign tail     = ring_add(head_ff, PW'(fill_ff));
   assign off_next = FW'(off_ff) + FW'(1);

   sacii_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (DEN_W'(off_ff) + DEN_W'(1)),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      last_in   = last_ff;
      start_in  = start_ff;
      prev_in   = prev_ff;
      off_in    = off_ff;
      endp_in   = endp_ff;
      val_in    = val_ff;
      num_in    = num_ff;
      emit_in   = 1'b0;
      in_pop    = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = tail;
      mem_wd    = in_sample;
      mem_ra    = head_ff;
      div_start = 1'b0;
      oq_push   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               in_pop   = 1'b1;
               mem_we   = 1'b1;
               fill_in  = fill_ff + FW'(1);
               last_in  = in_last;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (emit_ff && oq_full) begin
               state_in = S_EVAL;
               emit_in  = 1'b1;
            end else begin
               if (emit_ff) begin
                  // hand the finished word over and retire the head
                  oq_push  = 1'b1;
                  prev_in  = val_ff;
                  start_in = 1'b0;
                  head_in  = ring_add(head_ff, PW'(1));
                  fill_in  = fill_ff - FW'(1);
               end
               if (fill_in == '0) begin
                  if (last_ff) begin
                     start_in = 1'b1;
                     prev_in  = '0;
                     last_in  = 1'b0;
                     head_in  = '0;
                  end
                  state_in = S_IDLE;
               end else begin
                  mem_ra   = head_in;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (start_ff) begin
               val_in   = is_stuck(rd_ff[5:0]) ? ped : rd_ff;
               emit_in  = 1'b1;
               state_in = S_EVAL;
            end else if (!is_stuck(rd_ff[5:0])) begin
               val_in   = rd_ff;
               emit_in  = 1'b1;
               state_in = S_EVAL;
            end else begin
               off_in   = '0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if ((off_ff >= lim) || ((off_next >= fill_ff) && last_ff)) begin
               // search gave up: the boundary sample turns into the pedestal
               mem_we   = 1'b1;
               mem_wa   = ring_add(head_ff, off_ff);
               mem_wd   = ped;
               endp_in  = ped;
               state_in = S_MUL;
            end else if (off_next >= fill_ff) begin
               state_in = S_IDLE;
            end else begin
               off_in   = off_ff + PW'(1);
               mem_ra   = ring_add(head_ff, off_ff + PW'(1));
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (!is_stuck(rd_ff[5:0])) begin
               endp_in  = rd_ff;
               state_in = S_MUL;
            end else begin
               state_in = S_SRCH;
            end
         end
         S_MUL: begin
            // floor((p*d + e - p) / d) with d = off + 1
            num_in   = NUM_W'(prev_ff) * NUM_W'(off_ff) + NUM_W'(endp_ff);
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               val_in   = SW'(div_quot);
               emit_in  = 1'b1;
               state_in = S_EVAL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         fill_ff  <= '0;
         last_ff  <= 1'b0;
         start_ff <= 1'b1;
         prev_ff  <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         last_ff  <= last_in;
         start_ff <= start_in;
         prev_ff  <= prev_in;
         emit_ff  <= emit_in;
      end
      off_ff  <= off_in;
      endp_ff <= endp_in;
      val_ff  <= val_in;
      num_ff  <= num_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem_ff[mem_wa] <= mem_wd;
      end
      rd_ff <= win_mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         arr_ff[tail] <= in_stuck;
      end
   end

   // result queue
   assign oq_full   = (oq_cnt_ff == 2'd2);
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign oq_pop    = rsp_pop && !rsp_empty;
   assign rsp_word  = oq_ff[oq_rp_ff];

   always_comb begin
      oq_word.corrected_sample = SAMPLE_BITS'(val_ff);
      oq_word.was_replaced     = arr_ff[head_ff];
      oq_word.end_of_waveform  = last_ff && (fill_ff == FW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wp_ff  <= 1'b0;
         oq_rp_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         if (oq_push) oq_wp_ff <= !oq_wp_ff;
         if (oq_pop) oq_rp_ff <= !oq_rp_ff;
         oq_cnt_ff <= oq_cnt_ff + 2'(oq_push) - 2'(oq_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wp_ff] <= oq_word;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> fill_ff <= FW'(MAX_RUN))
      else $error("window holds more than the run limit between words");

   a_div_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_done) |=> (state_ff == S_EVAL && emit_ff))
      else $error("divider result not handed to the result stage");

   a_wave_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && !emit_ff && fill_ff == '0 && last_ff)
      |=> (start_ff && prev_ff == '0 && state_ff == S_IDLE))
      else $error("waveform end did not restart the interpolator");

endmodule

@@ rtl/core/stuck_adc_code_interpolator_unit.sv @@
// top level of the stuck adc code interpolator
//
//  channel | direction | handshake           | word
//  req_    | in        | req_push / req_full  | req_word_type (sample, last flag)
//  rsp_    | out       | rsp_pop / rsp_empty  | rsp_word_type (sample, replaced, end)
//  csr_    | in        | csr_valid / csr_ready| csr_index, csr_wdata
//
// a good sample passes the back end through its idle, eval and head states; a stuck
// one adds a search and a check state per look-ahead entry read from the window memory,
// then the multiply and divider start states and the bit-serial divider for one result.
// reset is synchronous; the window memory needs no clearing pass.
// a full result queue stalls the back end only; the 2-word input queue accepts until full.
module stuck_adc_code_interpolator_unit #(
   parameter int MAX_RUN = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  sacii_pkg::req_word_type                  req_word,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output sacii_pkg::rsp_word_type                  rsp_word,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sacii_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sacii_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import sacii_pkg::*;

   logic [4:0]             limit_ff;
   logic [11:0]            ped_ff;
   logic                   f_valid, f_pop, f_last, f_stuck;
   logic [SAMPLE_BITS-1:0] f_sample;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RUN_LIMIT_RESET;
         ped_ff   <= PEDESTAL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RUN_LIMIT: limit_ff <= csr_wdata[4:0];
            CSR_PEDESTAL:  ped_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sacii_front #(.SW(SAMPLE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .in_word    (req_word),
      .full       (req_full),
      .out_valid  (f_valid),
      .out_pop    (f_pop),
      .out_sample (f_sample),
      .out_last   (f_last),
      .out_stuck  (f_stuck)
   );

   sacii_back #(.MAX_RUN(MAX_RUN), .SW(SAMPLE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .pedestal  (ped_ff),
      .in_valid  (f_valid),
      .in_pop    (f_pop),
      .in_sample (f_sample),
      .in_last   (f_last),
      .in_stuck  (f_stuck),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule
